/* rtl/core/mf3_pkg.sv */
`default_nettype none

package mf3_pkg;

   // image geometry limits
   localparam int MAX_WIDTH    = 1024;
   localparam int MAX_HEIGHT   = 4095;
   localparam int MIN_SIZE     = 3;
   localparam int RESET_WIDTH  = 640;
   localparam int RESET_HEIGHT = 480;

   // pixel format
   localparam int CHANNEL_BITS = 8;
   localparam int NUM_CHANNELS = 3;
   localparam int PIX_BITS     = NUM_CHANNELS * CHANNEL_BITS;
   localparam int NB_CELLS     = 9;

   // register port
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 12;
   localparam int CFG_WIDTH_BITS  = 11;
   localparam int CFG_HEIGHT_BITS = 12;

   // counters
   localparam int COL_BITS    = $clog2(MAX_WIDTH);
   localparam int WIDTH_BITS  = $clog2(MAX_WIDTH + 1);
   localparam int HEIGHT_BITS = CFG_HEIGHT_BITS;
   localparam int ROW_BITS    = HEIGHT_BITS + 1;
   localparam int TOTAL_BITS  = WIDTH_BITS + HEIGHT_BITS;

   // register indexes of the csr port; the spare ones are ignored
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_IMAGE_WIDTH  = CSR_INDEX_BITS'(0),
      REG_IMAGE_HEIGHT = CSR_INDEX_BITS'(1),
      REG_SPARE_2      = CSR_INDEX_BITS'(2),
      REG_SPARE_3      = CSR_INDEX_BITS'(3)
   } csr_reg_type;

   // what an input item carries
   typedef enum logic {
      KIND_PIXEL = 1'b0,
      KIND_DRAIN = 1'b1
   } item_kind_type;

   typedef logic [CHANNEL_BITS-1:0] chan_type;
   typedef logic [PIX_BITS-1:0]     pix_type;

   // one neighbourhood, cells in row-major order, top-left first
   typedef struct packed {
      pix_type [NB_CELLS-1:0] cells;
      logic    [NB_CELLS-1:0] mask;
      logic                   frame_end;
   } nbhd_type;

endpackage

`default_nettype wire

/* rtl/core/mf3_ram.sv */
`default_nettype none

module mf3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/core/mf3_window.sv */
`default_nettype none

module mf3_window
   import mf3_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_kind,
   input  chan_type                  req_red_in,
   input  chan_type                  req_green_in,
   input  chan_type                  req_blue_in,
   output logic                      nb_valid,
   input  logic                      nb_ready,
   output nbhd_type                  nb
);

   localparam int CLAMP_BITS = CSR_DATA_BITS + 1;

   logic [WIDTH_BITS-1:0]  width_ff, width_in;
   logic [HEIGHT_BITS-1:0] height_ff, height_in;
   logic [TOTAL_BITS-1:0]  total_m1_ff, total_m1_in;
   logic [COL_BITS-1:0]    col_ff, col_in;
   logic [ROW_BITS-1:0]    row_ff, row_in;
   logic [TOTAL_BITS-1:0]  out_count_ff, out_count_in;
   logic [CLAMP_BITS-1:0]  w_val, h_val;
   logic                   cfg_hit;

   logic [COL_BITS-1:0]    k;
   logic [WIDTH_BITS-1:0]  k_next;
   logic                   draining, ignored, case_a, case_b, emit, frame_end, k_ge2;
   logic [2:0]             col_ok, row_ok;
   logic [NB_CELLS-1:0]    mask;
   pix_type                pix;
   logic                   load1;

   logic                   v1_ff, v1_in;
   pix_type                pix1_ff;
   logic [COL_BITS-1:0]    k1_ff;
   logic                   emit1_ff, fe1_ff, byp1_ff, byp_in;
   logic [NB_CELLS-1:0]    mask1_ff;
   pix_type                bypd1_ff;
   logic                   transfer1, ready1, s2_free;
   pix_type                a_dout, b_dout, old_b;
   pix_type                win_ff [3][3];
   pix_type                win_in [3][3];
   logic                   v2_ff, v2_in;
   nbhd_type               nb_ff, nb_in;

   // register writes, clamped to the legal image size
   always_comb begin
      w_val = CLAMP_BITS'(csr_wdata[CFG_WIDTH_BITS-1:0]);
      if (w_val < CLAMP_BITS'(MIN_SIZE)) begin
         w_val = CLAMP_BITS'(MIN_SIZE);
      end else if (w_val > CLAMP_BITS'(MAX_WIDTH)) begin
         w_val = CLAMP_BITS'(MAX_WIDTH);
      end
      h_val = CLAMP_BITS'(csr_wdata[CFG_HEIGHT_BITS-1:0]);
      if (h_val < CLAMP_BITS'(MIN_SIZE)) begin
         h_val = CLAMP_BITS'(MIN_SIZE);
      end else if (h_val > CLAMP_BITS'(MAX_HEIGHT)) begin
         h_val = CLAMP_BITS'(MAX_HEIGHT);
      end
      width_in  = width_ff;
      height_in = height_ff;
      cfg_hit   = 1'b0;
      if (csr_wr_en) begin
         case (csr_index)
            REG_IMAGE_WIDTH: begin
               width_in = WIDTH_BITS'(w_val);
               cfg_hit  = 1'b1;
            end
            REG_IMAGE_HEIGHT: begin
               height_in = HEIGHT_BITS'(h_val);
               cfg_hit   = 1'b1;
            end
            default: begin
               cfg_hit = 1'b0;
            end
         endcase
      end
      total_m1_in = TOTAL_BITS'(width_ff) * TOTAL_BITS'(height_ff) - TOTAL_BITS'(1);
   end

   // position decode for the incoming item
   always_comb begin
      k = col_ff;
      if (WIDTH_BITS'(col_ff) >= width_ff) begin
         k = '0;
      end
      draining = row_ff >= ROW_BITS'(height_ff);
      ignored  = !draining && (req_kind == KIND_DRAIN);
      pix      = draining ? '0 : {req_blue_in, req_green_in, req_red_in};
      k_ge2    = k >= COL_BITS'(2);
      // end of row: centre is the last pixel two rows up, window not yet shifted
      case_a   = (k == '0) && (row_ff >= ROW_BITS'(2));
      case_b   = (k != '0) && (row_ff != '0);
      emit     = case_a || case_b;
      col_ok   = case_a ? 3'b011 : {2'b11, k_ge2};
      row_ok[0] = case_a ? (row_ff >= ROW_BITS'(3)) : (row_ff >= ROW_BITS'(2));
      row_ok[1] = 1'b1;
      row_ok[2] = case_a ? (row_ff <= ROW_BITS'(height_ff)) : (row_ff < ROW_BITS'(height_ff));
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            mask[r*3+c] = col_ok[c] && row_ok[r];
         end
      end
      frame_end = emit && (out_count_ff == total_m1_ff);
      k_next    = WIDTH_BITS'(k) + WIDTH_BITS'(1);
   end

   // handshake between input, line store stage and neighbourhood register
   always_comb begin
      s2_free   = !v2_ff || nb_ready;
      transfer1 = v1_ff && (!emit1_ff || s2_free);
      ready1    = !v1_ff || transfer1;
      req_stall = !ready1;
      load1     = req_valid && ready1 && !ignored;
      v1_in     = load1 || (v1_ff && !transfer1);
      byp_in    = transfer1 && (k == k1_ff);
      if (transfer1 && emit1_ff) begin
         v2_in = 1'b1;
      end else if (nb_ready) begin
         v2_in = 1'b0;
      end else begin
         v2_in = v2_ff;
      end
   end

   // frame counters
   always_comb begin
      col_in       = col_ff;
      row_in       = row_ff;
      out_count_in = out_count_ff;
      if (cfg_hit) begin
         col_in       = '0;
         row_in       = '0;
         out_count_in = '0;
      end else if (load1) begin
         if (frame_end) begin
            col_in       = '0;
            row_in       = '0;
            out_count_in = '0;
         end else begin
            if (k_next >= width_ff) begin
               col_in = '0;
               row_in = row_ff + ROW_BITS'(1);
            end else begin
               col_in = COL_BITS'(k_next);
            end
            if (emit) begin
               out_count_in = out_count_ff + TOTAL_BITS'(1);
            end
         end
      end
   end

   // window shift and neighbourhood gather
   always_comb begin
      old_b = byp1_ff ? bypd1_ff : b_dout;
      for (int r = 0; r < 3; r++) begin
         win_in[0][r] = win_ff[1][r];
         win_in[1][r] = win_ff[2][r];
      end
      win_in[2][0] = old_b;
      win_in[2][1] = a_dout;
      win_in[2][2] = pix1_ff;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            nb_in.cells[r*3+c] = win_in[c][r];
         end
      end
      nb_in.mask      = mask1_ff;
      nb_in.frame_end = fe1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_BITS'(RESET_WIDTH);
         height_ff    <= HEIGHT_BITS'(RESET_HEIGHT);
         total_m1_ff  <= TOTAL_BITS'(RESET_WIDTH * RESET_HEIGHT - 1);
         col_ff       <= '0;
         row_ff       <= '0;
         out_count_ff <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         total_m1_ff  <= total_m1_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         out_count_ff <= out_count_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
      end
      if (load1) begin
         pix1_ff  <= pix;
         k1_ff    <= k;
         emit1_ff <= emit;
         mask1_ff <= mask;
         fe1_ff   <= frame_end;
         byp1_ff  <= byp_in;
         bypd1_ff <= a_dout;
      end
      if (transfer1) begin
         win_ff <= win_in;
      end
      if (transfer1 && emit1_ff) begin
         nb_ff <= nb_in;
      end
   end

   // row above the current one
   mf3_ram #(
      .WIDTH (PIX_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line_a (
      .clock   (clock),
      .wr_en   (load1),
      .wr_addr (k),
      .wr_data (pix),
      .rd_en   (load1),
      .rd_addr (k),
      .rd_data (a_dout)
   );

   // two rows above; written when the older row value has come out of line a
   mf3_ram #(
      .WIDTH (PIX_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line_b (
      .clock   (clock),
      .wr_en   (transfer1),
      .wr_addr (k1_ff),
      .wr_data (a_dout),
      .rd_en   (load1),
      .rd_addr (k),
      .rd_data (b_dout)
   );

   assign nb_valid = v2_ff;
   assign nb       = nb_ff;

endmodule

`default_nettype wire

/* rtl/core/mf3_median.sv */
`default_nettype none

module mf3_median
   import mf3_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     nb_valid,
   output logic     nb_ready,
   input  nbhd_type nb,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output chan_type rsp_red_out,
   output chan_type rsp_green_out,
   output chan_type rsp_blue_out,
   output logic     rsp_frame_end
);

   localparam int CNT_BITS   = $clog2(NB_CELLS + 1);
   localparam int ROWS       = 3;
   localparam int EDGE_COUNT = 6;

   typedef struct packed {
      chan_type hi;
      chan_type mid;
      chan_type lo;
   } trio_type;

   function automatic chan_type min2(chan_type a, chan_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic chan_type max2(chan_type a, chan_type b);
      return (a < b) ? b : a;
   endfunction

   function automatic trio_type sort3(chan_type a, chan_type b, chan_type c);
      trio_type t;
      chan_type x;
      chan_type y;
      x = min2(a, b);
      y = max2(a, b);
      if (c < x) begin
         t.lo  = c;
         t.mid = x;
         t.hi  = y;
      end else if (c < y) begin
         t.lo  = x;
         t.mid = c;
         t.hi  = y;
      end else begin
         t.lo  = x;
         t.mid = y;
         t.hi  = c;
      end
      return t;
   endfunction

   logic                vp_ff, vs_ff, vc_ff, vo_ff;
   logic                fep_ff, fes_ff, fec_ff, feo_ff;
   logic                rdy_o, rdy_c, rdy_s, rdy_p;
   logic [CNT_BITS-1:0] n_valid, seen;
   logic [1:0]          n_zeros;
   logic [NB_CELLS-1:0] zero_fill;
   chan_type            pad_ff  [NUM_CHANNELS][NB_CELLS];
   chan_type            pad_in  [NUM_CHANNELS][NB_CELLS];
   trio_type            srt_ff  [NUM_CHANNELS][ROWS];
   trio_type            srt_in  [NUM_CHANNELS][ROWS];
   chan_type            cand_ff [NUM_CHANNELS][ROWS];
   chan_type            cand_in [NUM_CHANNELS][ROWS];
   chan_type            med_ff  [NUM_CHANNELS];
   chan_type            med_in  [NUM_CHANNELS];

   // missing neighbours are padded with zeros and full-scale values so that the
   // median of nine lands on the upper median of the cells inside the image
   always_comb begin
      n_valid = CNT_BITS'($countones(nb.mask));
      if (n_valid == CNT_BITS'(NB_CELLS)) begin
         n_zeros = 2'd0;
      end else if (n_valid == CNT_BITS'(EDGE_COUNT)) begin
         n_zeros = 2'd1;
      end else begin
         n_zeros = 2'd2;
      end
      seen = '0;
      for (int i = 0; i < NB_CELLS; i++) begin
         zero_fill[i] = seen < CNT_BITS'(n_zeros);
         if (!nb.mask[i]) begin
            seen = seen + CNT_BITS'(1);
         end
      end
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
         for (int i = 0; i < NB_CELLS; i++) begin
            if (nb.mask[i]) begin
               pad_in[ch][i] = nb.cells[i][ch*CHANNEL_BITS +: CHANNEL_BITS];
            end else if (zero_fill[i]) begin
               pad_in[ch][i] = '0;
            end else begin
               pad_in[ch][i] = '1;
            end
         end
      end
   end

   // sort each row, then max of lows, median of mids, min of highs
   always_comb begin
      trio_type tmp;
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
         for (int r = 0; r < ROWS; r++) begin
            srt_in[ch][r] = sort3(pad_ff[ch][r*3], pad_ff[ch][r*3+1], pad_ff[ch][r*3+2]);
         end
         cand_in[ch][0] = max2(max2(srt_ff[ch][0].lo, srt_ff[ch][1].lo), srt_ff[ch][2].lo);
         tmp = sort3(srt_ff[ch][0].mid, srt_ff[ch][1].mid, srt_ff[ch][2].mid);
         cand_in[ch][1] = tmp.mid;
         cand_in[ch][2] = min2(min2(srt_ff[ch][0].hi, srt_ff[ch][1].hi), srt_ff[ch][2].hi);
      end
   end

   always_comb begin
      trio_type fin;
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
         fin        = sort3(cand_ff[ch][0], cand_ff[ch][1], cand_ff[ch][2]);
         med_in[ch] = fin.mid;
      end
   end

   // each stage moves on when the one ahead is empty or moving
   always_comb begin
      rdy_o    = !vo_ff || !rsp_stall;
      rdy_c    = !vc_ff || rdy_o;
      rdy_s    = !vs_ff || rdy_c;
      rdy_p    = !vp_ff || rdy_s;
      nb_ready = rdy_p;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_ff <= 1'b0;
         vs_ff <= 1'b0;
         vc_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (rdy_p) begin
            vp_ff <= nb_valid;
         end
         if (rdy_s) begin
            vs_ff <= vp_ff;
         end
         if (rdy_c) begin
            vc_ff <= vs_ff;
         end
         if (rdy_o) begin
            vo_ff <= vc_ff;
         end
      end
      if (rdy_p) begin
         pad_ff <= pad_in;
         fep_ff <= nb.frame_end;
      end
      if (rdy_s) begin
         srt_ff <= srt_in;
         fes_ff <= fep_ff;
      end
      if (rdy_c) begin
         cand_ff <= cand_in;
         fec_ff  <= fes_ff;
      end
      if (rdy_o) begin
         med_ff <= med_in;
         feo_ff <= fec_ff;
      end
   end

   assign rsp_valid     = vo_ff;
   assign rsp_red_out   = med_ff[0];
   assign rsp_green_out = med_ff[1];
   assign rsp_blue_out  = med_ff[2];
   assign rsp_frame_end = feo_ff;

endmodule

`default_nettype wire

/* rtl/core/median_filter_3x3_unit.sv */
// 3x3 per-channel median filter for a raster-order RGB pixel stream.
// req channel: one item per pixel (kind 0) with its red, green and blue values;
// after the last pixel of a frame, send drain items (kind 1) until the result
// with frame_end set comes out. A drain item during the pixel phase is dropped.
// rsp channel: one result per image pixel, in raster order, each channel the
// upper median of the 4, 6 or 9 neighbours that lie inside the image.
// csr port: image_width (index 0) and image_height (index 1), clamped to the
// legal range; a write restarts the frame. Write only while the block is idle.
// Throughput: one item per cycle while req_stall is low; each line store does one read and one write
// per item, and while rsp is not stalled every stage behind them takes a new neighbourhood each cycle.
// The result for a pixel is produced by the item one row plus one pixel after
// it and reaches rsp through the registered steps line store read, gather,
// pad, row sort, candidate and output.
// A stalled rsp holds its result; the stages behind it keep taking items until
// they are full, then req_stall rises.
// Reset (synchronous) empties the pipeline, zeroes the frame counters and
// restores 640x480. The line stores are not cleared; rows above the image are
// masked off.
`default_nettype none

module median_filter_3x3_unit
   import mf3_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_kind,
   input  chan_type                  req_red_in,
   input  chan_type                  req_green_in,
   input  chan_type                  req_blue_in,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output chan_type                  rsp_red_out,
   output chan_type                  rsp_green_out,
   output chan_type                  rsp_blue_out,
   output logic                      rsp_frame_end
);

   localparam int CENTER_CELL = NB_CELLS / 2;

   // neighbourhood handoff from the window to the median pipeline
   logic     nb_valid;
   logic     nb_ready;
   nbhd_type nb;

   // line stores, counters and 3x3 window
   mf3_window u_window (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_kind     (req_kind),
      .req_red_in   (req_red_in),
      .req_green_in (req_green_in),
      .req_blue_in  (req_blue_in),
      .nb_valid     (nb_valid),
      .nb_ready     (nb_ready),
      .nb           (nb)
   );

   // padded median network, ends in the output register
   mf3_median u_median (
      .clock         (clock),
      .reset         (reset),
      .nb_valid      (nb_valid),
      .nb_ready      (nb_ready),
      .nb            (nb),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_frame_end (rsp_frame_end)
   );

   // a neighbourhood is always a full window, an edge strip or a corner
   nb_count_legal: assert property (@(posedge clock) disable iff (reset)
      nb_valid |-> ($countones(nb.mask) == 4 || $countones(nb.mask) == 6 ||
                    $countones(nb.mask) == 9))
      else $error("neighbourhood with an illegal cell count");

   // the centre pixel always lies in the image
   nb_center_valid: assert property (@(posedge clock) disable iff (reset)
      nb_valid |-> nb.mask[CENTER_CELL])
      else $error("neighbourhood centre masked off");

   // with an empty output register nothing may hold back the input
   no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with an empty output");

endmodule

`default_nettype wire

/* bench/median_filter_3x3_checker.sv */
`timescale 1ns / 1ps

package mf3_tb_pkg;
   import mf3_pkg::*;

   typedef struct packed {
      chan_type red;
      chan_type green;
      chan_type blue;
      logic     frame_end;
   } median_result_type;

endpackage

module median_filter_3x3_checker
   import mf3_pkg::*;
   import mf3_tb_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic                      req_kind,
   input  chan_type                  req_red_in,
   input  chan_type                  req_green_in,
   input  chan_type                  req_blue_in,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  chan_type                  rsp_red_out,
   input  chan_type                  rsp_green_out,
   input  chan_type                  rsp_blue_out,
   input  logic                      rsp_frame_end,
   output int                        fail_count,
   output int                        open_count,
   output int                        checked_count
);

   logic [WIDTH_BITS-1:0]  geom_w;
   logic [HEIGHT_BITS-1:0] geom_h;
   logic [WIDTH_BITS-1:0]  col_pos;
   logic [ROW_BITS-1:0]    row_pos;
   logic [TOTAL_BITS-1:0]  emitted;
   pix_type                row_above [MAX_WIDTH];
   pix_type                two_above [MAX_WIDTH];
   pix_type                win [NB_CELLS];   // column * 3 + row, row 0 on top
   median_result_type      pending_medians [$];
   int                     failures = 0;
   int                     checked = 0;
   int                     reports = 0;

   // upper median per channel of the in-image cells of one window
   function automatic median_result_type window_median(input int lc, input int mc,
                                                       input int rc,
                                                       input bit left_ok, input bit right_ok,
                                                       input bit top_ok, input bit bottom_ok);
      int                    cols [3];
      bit                    col_ok [3];
      bit                    row_ok [3];
      chan_type              vals [NB_CELLS];
      chan_type              med [NUM_CHANNELS];
      chan_type              t;
      logic [TOTAL_BITS-1:0] total;
      median_result_type     res;
      int                    n, ch, r, c, i, j;
      cols   = '{lc, mc, rc};
      col_ok = '{left_ok, 1'b1, right_ok};
      row_ok = '{top_ok, 1'b1, bottom_ok};
      for (ch = 0; ch < NUM_CHANNELS; ch++) begin
         n = 0;
         for (r = 0; r < 3; r++)
            for (c = 0; c < 3; c++)
               if (col_ok[c] && row_ok[r]) begin
                  vals[n] = win[cols[c] * 3 + r][ch * CHANNEL_BITS +: CHANNEL_BITS];
                  n++;
               end
         for (i = 1; i < n; i++) begin
            t = vals[i];
            j = i;
            while (j > 0 && vals[j - 1] > t) begin
               vals[j] = vals[j - 1];
               j--;
            end
            vals[j] = t;
         end
         med[ch] = vals[n / 2];
      end
      total         = TOTAL_BITS'(geom_w) * TOTAL_BITS'(geom_h);
      res.red       = med[0];
      res.green     = med[1];
      res.blue      = med[2];
      res.frame_end = (emitted == total - TOTAL_BITS'(1));
      return res;
   endfunction

   function automatic void apply_register(input logic [CSR_INDEX_BITS-1:0] idx,
                                          input logic [CSR_DATA_BITS-1:0] value);
      int unsigned v;
      case (idx)
         REG_IMAGE_WIDTH: begin
            v = 32'(value[CFG_WIDTH_BITS-1:0]);
            if (v < MIN_SIZE) v = MIN_SIZE;
            if (v > MAX_WIDTH) v = MAX_WIDTH;
            geom_w = WIDTH_BITS'(v);
         end
         REG_IMAGE_HEIGHT: begin
            v = 32'(value[CFG_HEIGHT_BITS-1:0]);
            if (v < MIN_SIZE) v = MIN_SIZE;
            if (v > MAX_HEIGHT) v = MAX_HEIGHT;
            geom_h = HEIGHT_BITS'(v);
         end
         default: return;
      endcase
      col_pos = '0;
      row_pos = '0;
      emitted = '0;
   endfunction

   // one accepted item: shift the window, update the line stores, queue a median if one is due
   function automatic void advance_raster(input item_kind_type kind, input chan_type r,
                                          input chan_type g, input chan_type b);
      pix_type               fresh, up1, up2;
      logic [WIDTH_BITS-1:0] k;
      logic [ROW_BITS-1:0]   row;
      median_result_type     res;
      bit                    draining, made;
      int                    i;
      draining = (row_pos >= ROW_BITS'(geom_h));
      if (!draining && kind == KIND_DRAIN) return;
      fresh = draining ? '0 : {b, g, r};
      k     = (col_pos >= geom_w) ? '0 : col_pos;
      row   = row_pos;
      made  = 1'b0;
      // row start: last pixel of the row two above, window not yet shifted
      if (k == 0 && row >= 2) begin
         res  = window_median(1, 2, 2, 1'b1, 1'b0, row >= 3, (row - 1) < geom_h);
         made = 1'b1;
      end
      up1 = row_above[COL_BITS'(k)];
      up2 = two_above[COL_BITS'(k)];
      for (i = 0; i < 6; i++) win[i] = win[i + 3];
      win[6]                   = up2;
      win[7]                   = up1;
      win[8]                   = fresh;
      two_above[COL_BITS'(k)]  = up1;
      row_above[COL_BITS'(k)]  = fresh;
      if (k >= 1 && row >= 1) begin
         res  = window_median(0, 1, 2, k >= 2, 1'b1, row >= 2, row < geom_h);
         made = 1'b1;
      end
      k = k + 1'b1;
      if (k >= geom_w) begin
         k   = '0;
         row = row + 1'b1;
      end
      col_pos = k;
      row_pos = row;
      if (!made) return;
      pending_medians.insert(pending_medians.size(), res);
      if (res.frame_end) begin
         col_pos = '0;
         row_pos = '0;
         emitted = '0;
      end else begin
         emitted = emitted + 1'b1;
      end
   endfunction

   always @(posedge clock) begin : watch
      median_result_type want;
      int                i;
      if (reset) begin
         geom_w  = WIDTH_BITS'(RESET_WIDTH);
         geom_h  = HEIGHT_BITS'(RESET_HEIGHT);
         col_pos = '0;
         row_pos = '0;
         emitted = '0;
         for (i = 0; i < NB_CELLS; i++) win[i] = '0;
         for (i = 0; i < MAX_WIDTH; i++) begin
            row_above[i] = '0;
            two_above[i] = '0;
         end
         pending_medians.delete();
      end else begin
         if (csr_wr_en) apply_register(csr_index, csr_wdata);
         if (req_valid && !req_stall)
            advance_raster(item_kind_type'(req_kind), req_red_in, req_green_in,
                           req_blue_in);
         if (rsp_valid && !rsp_stall) begin
            if (pending_medians.size() == 0) begin
               failures++;
               if (reports < 10)
                  $display("unexpected result: r=%0d g=%0d b=%0d end=%0d",
                           rsp_red_out, rsp_green_out, rsp_blue_out, rsp_frame_end);
               reports++;
            end else begin
               want = pending_medians.pop_front();
               if (want.red !== rsp_red_out || want.green !== rsp_green_out ||
                   want.blue !== rsp_blue_out || want.frame_end !== rsp_frame_end) begin
                  failures++;
                  if (reports < 10)
                     $display("median %0d: expected r=%0d g=%0d b=%0d end=%0d, ",
                              checked, want.red, want.green, want.blue, want.frame_end,
                              "got r=%0d g=%0d b=%0d end=%0d",
                              rsp_red_out, rsp_green_out, rsp_blue_out, rsp_frame_end);
                  reports++;
               end
               checked++;
            end
         end
      end
      open_count    <= pending_medians.size();
      fail_count    <= failures;
      checked_count <= checked;
   end

endmodule

/* bench/tb_median_filter_3x3_unit.sv */
`timescale 1ns / 1ps

module tb_median_filter_3x3_unit;
   import mf3_pkg::*;
   import mf3_tb_pkg::*;

   // result leaves only after the item that completes its window has been taken
   localparam int RSP_LATENCY   = 5;
   localparam int SETTLE_CYCLES = 2 * RSP_LATENCY;
   localparam int RANDOM_ITEMS  = 280;
   localparam int HOLD_CYCLES   = 400;
   localparam int HOLD_WIDTH    = 16;
   localparam int HOLD_HEIGHT   = 4;
   localparam int PARTIAL_ROW   = 30;
   localparam chan_type CH_MAX  = '1;
   localparam chan_type CH_MIN  = '0;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_kind = 1'b0;
   chan_type                  req_red_in = '0;
   chan_type                  req_green_in = '0;
   chan_type                  req_blue_in = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   chan_type                  rsp_red_out;
   chan_type                  rsp_green_out;
   chan_type                  rsp_blue_out;
   logic                      rsp_frame_end;

   // from the checker
   int                        fail_count;
   int                        open_count;
   int                        checked_count;

   // asks the receiver for one long hold-off
   logic                      long_hold_req = 1'b0;

   int                        burst_left = 8;
   int                        useful_items = 0;
   int                        frames_sent = 0;
   int                        frames_cut = 0;

   median_filter_3x3_unit dut (.*);

   median_filter_3x3_checker result_check (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   // hard limit on the whole run
   initial begin
      #50_000_000;
      $display("timed out waiting for the block");
      $display("== FAIL ==");
      $finish;
   end

   // mostly random, some extremes and a tight cluster so medians see ties
   function automatic chan_type pick_channel();
      case ($urandom_range(0, 3))
         0:       return $urandom_range(0, 1) ? CH_MAX : CH_MIN;
         1:       return chan_type'($urandom_range(100, 103));
         default: return chan_type'($urandom);
      endcase
   endfunction

   // offer one item and hold it until taken; bursts end in a random gap
   task automatic send_item(input item_kind_type kind, input chan_type r, input chan_type g,
                            input chan_type b);
      int gap;
      req_valid    <= 1'b1;
      req_kind     <= kind;
      req_red_in   <= r;
      req_green_in <= g;
      req_blue_in  <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         // now and then a long burst with no gaps at all
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
      end
   endtask

   // pixels then drain items; stray drains in the pixel phase are dropped by
   // the block, and a pixel in the drain phase counts as a drain
   task automatic send_frame(input int pixels, input int drains);
      int i;
      for (i = 0; i < pixels; i++) begin
         if ($urandom_range(0, 15) == 0)
            send_item(KIND_DRAIN, pick_channel(), pick_channel(), pick_channel());
         send_item(KIND_PIXEL, pick_channel(), pick_channel(), pick_channel());
         useful_items++;
      end
      for (i = 0; i < drains; i++) begin
         if ($urandom_range(0, 3) == 0)
            send_item(KIND_PIXEL, pick_channel(), pick_channel(), pick_channel());
         else
            send_item(KIND_DRAIN, pick_channel(), pick_channel(), pick_channel());
         useful_items++;
      end
   endtask

   task automatic write_csr(input csr_reg_type idx, input logic [CSR_DATA_BITS-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // stop sending until every expected median is out, then let stray items settle
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // receiver: stretches of different stall patterns, plus one long hold-off
   initial begin : receiver
      int mode, span, j;
      bit held;
      held = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (long_hold_req && !held) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         mode = $urandom_range(0, 3);
         span = $urandom_range(10, 120);
         for (j = 0; j < span; j++) begin
            if (long_hold_req && !held) break;
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               2:       rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= ((j % 5) < 2);
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int w, h, cut, pixels, cur_w, cur_h, i;
      bit must_restart;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: ignored register indexes, clamped sizes, a 3x3 frame with extreme red and blue
      write_csr(REG_SPARE_2, CSR_DATA_BITS'($urandom));
      write_csr(REG_SPARE_3, CSR_DATA_BITS'($urandom));
      write_csr(REG_IMAGE_WIDTH, 12'h800);    // top bit masked off, clamps up to 3
      write_csr(REG_IMAGE_HEIGHT, 12'd1);     // clamps up to 3
      cur_w = MIN_SIZE;
      cur_h = MIN_SIZE;
      send_item(KIND_DRAIN, CH_MAX, CH_MAX, CH_MAX);    // dropped, pixel phase
      for (i = 0; i < 9; i++)
         send_item(KIND_PIXEL, (i % 2) ? CH_MAX : CH_MIN, chan_type'(i * 31),
                   (i >= 5) ? CH_MAX : CH_MIN);
      send_item(KIND_DRAIN, CH_MIN, CH_MIN, CH_MIN);
      send_item(KIND_PIXEL, CH_MAX, CH_MAX, CH_MAX);    // acts as a drain
      send_item(KIND_DRAIN, CH_MIN, CH_MIN, CH_MIN);
      send_item(KIND_DRAIN, CH_MAX, CH_MIN, CH_MAX);
      frames_sent++;
      wait_for_idle();

      // random frames, mostly small; some cut short and restarted by a write
      useful_items = 0;
      must_restart = 1'b0;
      while (useful_items < RANDOM_ITEMS) begin
         if (must_restart || $urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5, 6: w = $urandom_range(3, 8);
               7, 8:                w = $urandom_range(9, 20);
               default:             w = $urandom_range(21, 48);
            endcase
            h = (w > 20) ? MIN_SIZE : $urandom_range(3, 6);
            wait_for_idle();
            if ($urandom_range(0, 7) == 0) write_csr(REG_SPARE_3, CSR_DATA_BITS'($urandom));
            write_csr(REG_IMAGE_WIDTH, CSR_DATA_BITS'(w));
            if (h != cur_h || $urandom_range(0, 1))
               write_csr(REG_IMAGE_HEIGHT, CSR_DATA_BITS'(h));
            cur_w = w;
            cur_h = h;
         end
         // otherwise the next frame follows straight on, same geometry
         frames_sent++;
         if ($urandom_range(0, 6) == 0) begin
            cut    = $urandom_range(1, cur_w * cur_h + cur_w);
            pixels = (cut < cur_w * cur_h) ? cut : cur_w * cur_h;
            send_frame(pixels, cut - pixels);
            must_restart = 1'b1;
            frames_cut++;
         end else begin
            send_frame(cur_w * cur_h, cur_w + 1);
            must_restart = 1'b0;
         end
      end

      // oversize writes clamp to the widest row; a partial first row gives no result
      wait_for_idle();
      write_csr(REG_IMAGE_WIDTH, 12'h7FF);
      write_csr(REG_IMAGE_HEIGHT, 12'h000);
      send_frame(PARTIAL_ROW, 0);
      frames_sent++;
      frames_cut++;

      // receiver holds off for a long stretch while a whole frame keeps coming
      wait_for_idle();
      write_csr(REG_IMAGE_WIDTH, CSR_DATA_BITS'(HOLD_WIDTH));
      write_csr(REG_IMAGE_HEIGHT, CSR_DATA_BITS'(HOLD_HEIGHT));
      long_hold_req <= 1'b1;
      send_frame(HOLD_WIDTH * HOLD_HEIGHT, HOLD_WIDTH + 1);
      frames_sent++;
      wait_for_idle();

      $display("ran %0d frames (%0d cut short and restarted), %0d medians checked",
               frames_sent, frames_cut, checked_count);
      $display("sizes from 3x3 to 48 wide, clamped and ignored writes, one long output hold");
      if (open_count != 0)
         $display("%0d expected medians never came out", open_count);
      if (fail_count == 0 && open_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
